>>> hdl/tbr_pkg.sv
`timescale 1ns / 1ps

package tbr_pkg;

    localparam int BOUND_W    = 64;
    localparam int IN_DATA_W  = 520;
    localparam int OUT_DATA_W = 280;

    localparam logic REQ_INTERSECT = 1'b0;
    localparam logic REQ_UNION     = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_COMMON = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;
    localparam logic [1:0] ST_GAP       = 2'd3;

    localparam logic [1:0] ORD_LESS    = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;

    localparam logic [1:0] FLAG_VALUE = 2'b01;
    localparam logic [1:0] FLAG_TIME  = 2'b10;

    typedef logic signed [BOUND_W-1:0] bound_t;

    typedef struct packed {
        logic [1:0] flags;
        bound_t     xmin;
        bound_t     xmax;
        bound_t     tmin;
        bound_t     tmax;
    } box_t;

    // three-way outcome of one signed compare
    typedef struct packed {
        logic lt;
        logic gt;
    } ord_t;

    // all compares one dimension needs
    // lo: a.min vs b.min, hi: a.max vs b.max, aa: a.min vs a.max,
    // bb: b.min vs b.max, ab: a.min vs b.max, ba: b.min vs a.max
    typedef struct packed {
        ord_t lo;
        ord_t hi;
        ord_t aa;
        ord_t bb;
        ord_t ab;
        ord_t ba;
    } dim_cmp_t;

    typedef struct packed {
        logic [4:0] topo_bits;
        logic [3:0] value_pos_bits;
        logic [3:0] time_pos_bits;
        logic [1:0] order;
        logic       equal;
        logic [1:0] status;
        logic       box_valid;
        logic [1:0] box_flags;
        bound_t     box_xmin;
        bound_t     box_xmax;
        bound_t     box_tmin;
        bound_t     box_tmax;
    } result_t;

    function automatic ord_t cmp3(bound_t a, bound_t b);
        ord_t o;
        o.lt = (a < b);
        o.gt = (a > b);
        return o;
    endfunction

    function automatic logic is_eq(ord_t o);
        return !o.lt && !o.gt;
    endfunction

    // order of a chosen lower bound against a chosen upper bound
    function automatic ord_t pick_ord(dim_cmp_t c, logic lo_from_a, logic hi_from_a);
        ord_t o;
        unique case ({lo_from_a, hi_from_a})
            2'b11:   o = c.aa;
            2'b10:   o = c.ab;
            2'b01:   o = c.ba;
            default: o = c.bb;
        endcase
        return o;
    endfunction

endpackage

>>> hdl/tbr_dim_cmp.sv
`timescale 1ns / 1ps

module tbr_dim_cmp (
    input  tbr_pkg::bound_t   a_lo,
    input  tbr_pkg::bound_t   a_hi,
    input  tbr_pkg::bound_t   b_lo,
    input  tbr_pkg::bound_t   b_hi,
    output tbr_pkg::dim_cmp_t cmp_out
);

    always_comb
    begin
        cmp_out.lo = tbr_pkg::cmp3(a_lo, b_lo);
        cmp_out.hi = tbr_pkg::cmp3(a_hi, b_hi);
        cmp_out.aa = tbr_pkg::cmp3(a_lo, a_hi);
        cmp_out.bb = tbr_pkg::cmp3(b_lo, b_hi);
        cmp_out.ab = tbr_pkg::cmp3(a_lo, b_hi);
        cmp_out.ba = tbr_pkg::cmp3(b_lo, a_hi);
    end

endmodule

>>> hdl/tbr_relate.sv
`timescale 1ns / 1ps

module tbr_relate (
    input  logic              req_type,
    input  tbr_pkg::box_t     box_a,
    input  tbr_pkg::box_t     box_b,
    input  tbr_pkg::dim_cmp_t xc,
    input  tbr_pkg::dim_cmp_t tc,
    output tbr_pkg::result_t  res
);

    logic hx, ht, common;
    logic ovl_x, ovl_t, ovl, inter;
    logic same, adj, hold_ab, hold_ba;
    logic is_union;
    logic lo_a_x, hi_a_x, lo_a_t, hi_a_t;
    tbr_pkg::ord_t ix_ord, it_ord, rx_ord, rt_ord;
    tbr_pkg::bound_t x_lo, x_hi, t_lo, t_hi;
    logic valid;
    logic [1:0] rf;
    logic [1:0] status;
    logic [1:0] ord;
    logic eq;

    always_comb
    begin
        hx = box_a.flags[0] & box_b.flags[0];
        ht = box_a.flags[1] & box_b.flags[1];
        common = hx | ht;
        is_union = (req_type == tbr_pkg::REQ_UNION);

        ovl_x = !xc.ba.gt && !xc.ab.gt;
        ovl_t = !tc.ba.gt && !tc.ab.gt;
        ovl = (!hx || ovl_x) && (!ht || ovl_t);
        inter = common && ovl;

        same = (!hx || (tbr_pkg::is_eq(xc.lo) && tbr_pkg::is_eq(xc.hi)))
            && (!ht || (tbr_pkg::is_eq(tc.lo) && tbr_pkg::is_eq(tc.hi)));

        // intersection bounds: larger min, smaller max
        ix_ord = tbr_pkg::pick_ord(xc, !xc.lo.lt, !xc.hi.gt);
        it_ord = tbr_pkg::pick_ord(tc, !tc.lo.lt, !tc.hi.gt);
        adj = inter && ((hx && tbr_pkg::is_eq(ix_ord)) || (ht && tbr_pkg::is_eq(it_ord)));

        hold_ab = (!hx || (!xc.lo.gt && !xc.hi.lt)) && (!ht || (!tc.lo.gt && !tc.hi.lt));
        hold_ba = (!hx || (!xc.lo.lt && !xc.hi.gt)) && (!ht || (!tc.lo.lt && !tc.hi.gt));

        res.topo_bits = common ? {adj, same, ovl, hold_ba, hold_ab} : 5'd0;
        res.value_pos_bits = hx ? {!xc.lo.lt, xc.ab.gt, !xc.hi.gt, xc.ba.gt} : 4'd0;
        res.time_pos_bits  = ht ? {!tc.lo.lt, tc.ab.gt, !tc.hi.gt, tc.ba.gt} : 4'd0;

        // time first, then value, then flags
        priority if (ht && tc.lo.lt)      ord = tbr_pkg::ORD_LESS;
        else if (ht && tc.lo.gt)          ord = tbr_pkg::ORD_GREATER;
        else if (ht && tc.hi.lt)          ord = tbr_pkg::ORD_LESS;
        else if (ht && tc.hi.gt)          ord = tbr_pkg::ORD_GREATER;
        else if (hx && xc.lo.lt)          ord = tbr_pkg::ORD_LESS;
        else if (hx && xc.lo.gt)          ord = tbr_pkg::ORD_GREATER;
        else if (hx && xc.hi.lt)          ord = tbr_pkg::ORD_LESS;
        else if (hx && xc.hi.gt)          ord = tbr_pkg::ORD_GREATER;
        else if (box_a.flags < box_b.flags) ord = tbr_pkg::ORD_LESS;
        else if (box_a.flags > box_b.flags) ord = tbr_pkg::ORD_GREATER;
        else                              ord = tbr_pkg::ORD_EQUAL;
        res.order = ord;

        eq = (box_a.flags == box_b.flags)
            && (!box_a.flags[0] || (tbr_pkg::is_eq(xc.lo) && tbr_pkg::is_eq(xc.hi)))
            && (!box_a.flags[1] || (tbr_pkg::is_eq(tc.lo) && tbr_pkg::is_eq(tc.hi)));
        res.equal = eq;

        // union takes smaller min and larger max
        lo_a_x = is_union ? xc.lo.lt : !xc.lo.lt;
        hi_a_x = is_union ? xc.hi.gt : !xc.hi.gt;
        lo_a_t = is_union ? tc.lo.lt : !tc.lo.lt;
        hi_a_t = is_union ? tc.hi.gt : !tc.hi.gt;
        x_lo = lo_a_x ? box_a.xmin : box_b.xmin;
        x_hi = hi_a_x ? box_a.xmax : box_b.xmax;
        t_lo = lo_a_t ? box_a.tmin : box_b.tmin;
        t_hi = hi_a_t ? box_a.tmax : box_b.tmax;
        rx_ord = tbr_pkg::pick_ord(xc, lo_a_x, hi_a_x);
        rt_ord = tbr_pkg::pick_ord(tc, lo_a_t, hi_a_t);

        status = tbr_pkg::ST_OK;
        valid = 1'b0;
        if (!is_union)
        begin
            if (!common)
                status = tbr_pkg::ST_NO_COMMON;
            else if (inter)
                valid = 1'b1;
        end
        else
        begin
            priority if (box_a.flags != box_b.flags) status = tbr_pkg::ST_MISMATCH;
            else if (!common)                        status = tbr_pkg::ST_NO_COMMON;
            else if (!ovl)                           status = tbr_pkg::ST_GAP;
            else                                     valid = 1'b1;
        end
        rf = valid ? {ht, hx} : 2'b00;

        res.status = status;
        res.box_valid = valid;
        res.box_flags = rf;
        // inverted pairs come out in ascending order
        res.box_xmin = (rf & tbr_pkg::FLAG_VALUE) != 2'b00 ? (rx_ord.gt ? x_hi : x_lo) : '0;
        res.box_xmax = (rf & tbr_pkg::FLAG_VALUE) != 2'b00 ? (rx_ord.gt ? x_lo : x_hi) : '0;
        res.box_tmin = (rf & tbr_pkg::FLAG_TIME) != 2'b00 ? (rt_ord.gt ? t_hi : t_lo) : '0;
        res.box_tmax = (rf & tbr_pkg::FLAG_TIME) != 2'b00 ? (rt_ord.gt ? t_lo : t_hi) : '0;
    end

endmodule

>>> hdl/temporal_box_relation_unit.sv
`timescale 1ns / 1ps

// Relates two value-time boxes: topology, position predicates, equality, a
// three-way order and the intersection or union box with a status code. One
// box pair is taken every clock while the result side does not stall. The
// pipeline is an input register, one level of parallel 64-bit signed compares
// with min/max selection, and an output register that holds each result; a
// stall on the result side holds both stages and drops s_tready only when
// both are full.
module temporal_box_relation_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_flags, a_xmin, a_xmax, a_tmin, a_tmax, b_flags, b_xmin, b_xmax,
    // b_tmin, b_tmax, zero pad
    input  logic [tbr_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // topo_bits, value_pos_bits, time_pos_bits, order, equal, status,
    // box_valid, box_flags, box_xmin, box_xmax, box_tmin, box_tmax, zero pad
    output logic [tbr_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic in_valid_reg, in_valid_next;
    logic in_req_reg;
    logic [tbr_pkg::IN_DATA_W-1:0] in_data_reg;
    logic out_valid_reg, out_valid_next;
    tbr_pkg::result_t out_res_reg, out_res_next;
    logic adv;
    tbr_pkg::box_t box_a, box_b;
    tbr_pkg::dim_cmp_t xc, tc;

    assign adv = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = adv ? in_valid_reg : out_valid_reg;

    always_comb
    begin
        box_a.flags = in_data_reg[1:0];
        box_a.xmin  = in_data_reg[65:2];
        box_a.xmax  = in_data_reg[129:66];
        box_a.tmin  = in_data_reg[193:130];
        box_a.tmax  = in_data_reg[257:194];
        box_b.flags = in_data_reg[259:258];
        box_b.xmin  = in_data_reg[323:260];
        box_b.xmax  = in_data_reg[387:324];
        box_b.tmin  = in_data_reg[451:388];
        box_b.tmax  = in_data_reg[515:452];
    end

    tbr_dim_cmp u_cmp_x (
        .a_lo    (box_a.xmin),
        .a_hi    (box_a.xmax),
        .b_lo    (box_b.xmin),
        .b_hi    (box_b.xmax),
        .cmp_out (xc)
    );

    tbr_dim_cmp u_cmp_t (
        .a_lo    (box_a.tmin),
        .a_hi    (box_a.tmax),
        .b_lo    (box_b.tmin),
        .b_hi    (box_b.tmax),
        .cmp_out (tc)
    );

    tbr_relate u_relate (
        .req_type (in_req_reg),
        .box_a    (box_a),
        .box_b    (box_b),
        .xc       (xc),
        .tc       (tc),
        .res      (out_res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= s_tuser[0];
            in_data_reg <= s_tdata;
        end
        if (adv && in_valid_reg)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[4:0]     = out_res_reg.topo_bits;
        m_tdata[8:5]     = out_res_reg.value_pos_bits;
        m_tdata[12:9]    = out_res_reg.time_pos_bits;
        m_tdata[14:13]   = out_res_reg.order;
        m_tdata[15]      = out_res_reg.equal;
        m_tdata[17:16]   = out_res_reg.status;
        m_tdata[18]      = out_res_reg.box_valid;
        m_tdata[20:19]   = out_res_reg.box_flags;
        m_tdata[84:21]   = out_res_reg.box_xmin;
        m_tdata[148:85]  = out_res_reg.box_xmax;
        m_tdata[212:149] = out_res_reg.box_tmin;
        m_tdata[276:213] = out_res_reg.box_tmax;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import tbr_pkg::*;

    localparam int RANDOM_PAIRS = 650;
    localparam int QUIET_TAIL   = 80;
    localparam int HOLD_CYCLES  = 60;

    localparam bound_t BMAX = 64'sh7fff_ffff_ffff_ffff;
    localparam bound_t BMIN = 64'sh8000_0000_0000_0000;
    localparam bound_t Q1   = 64'sh0000_0001_0000_0000;

    localparam logic [1:0] NO_DIMS   = 2'b00;
    localparam logic [1:0] BOTH_DIMS = FLAG_VALUE | FLAG_TIME;

    typedef struct packed {
        logic req;
        box_t a;
        box_t b;
    } box_pair_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    box_pair_t pairs_to_send[$];
    result_t   expected_relations[$];
    box_pair_t on_bus;
    result_t   want;
    result_t   got;

    int  pairs_sent    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  input_stalls  = 0;
    int  directed_cnt  = 0;
    int  send_gap      = 0;
    int  take_gap      = 0;
    logic hold_off     = 1'b0;

    temporal_box_relation_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int three_way(bound_t x, bound_t y);
        return (x < y) ? -1 : ((x > y) ? 1 : 0);
    endfunction

    function automatic result_t relate_boxes(box_pair_t p);
        result_t r;
        bound_t  ax0, ax1, at0, at1, bx0, bx1, bt0, bt1;
        bound_t  ix0, ix1, it0, it1, rx0, rx1, rt0, rt1, lo;
        logic    hx, ht, common, ovl, same, adj, a_in_b, b_in_a;
        int      ord;
        r   = '0;
        ax0 = p.a.xmin;
        ax1 = p.a.xmax;
        at0 = p.a.tmin;
        at1 = p.a.tmax;
        bx0 = p.b.xmin;
        bx1 = p.b.xmax;
        bt0 = p.b.tmin;
        bt1 = p.b.tmax;
        rx0 = '0;
        rx1 = '0;
        rt0 = '0;
        rt1 = '0;

        hx     = p.a.flags[0] & p.b.flags[0];
        ht     = p.a.flags[1] & p.b.flags[1];
        common = hx | ht;
        ovl    = !(hx && (ax1 < bx0 || ax0 > bx1)) && !(ht && (at1 < bt0 || at0 > bt1));
        same   = !(hx && (ax0 != bx0 || ax1 != bx1)) && !(ht && (at0 != bt0 || at1 != bt1));
        b_in_a = !(hx && (bx0 < ax0 || bx1 > ax1)) && !(ht && (bt0 < at0 || bt1 > at1));
        a_in_b = !(hx && (ax0 < bx0 || ax1 > bx1)) && !(ht && (at0 < bt0 || at1 > bt1));

        ix0 = (ax0 > bx0) ? ax0 : bx0;
        ix1 = (ax1 < bx1) ? ax1 : bx1;
        it0 = (at0 > bt0) ? at0 : bt0;
        it1 = (at1 < bt1) ? at1 : bt1;
        adj = common && ovl && ((hx && ix0 == ix1) || (ht && it0 == it1));

        if (common)
            r.topo_bits = {adj, same, ovl, a_in_b, b_in_a};
        if (hx)
            r.value_pos_bits = {ax0 >= bx0, ax0 > bx1, ax1 <= bx1, ax1 < bx0};
        if (ht)
            r.time_pos_bits = {at0 >= bt0, at0 > bt1, at1 <= bt1, at1 < bt0};

        // time bounds first, then value bounds, then the flags themselves
        ord = 0;
        if (ht)
        begin
            ord = three_way(at0, bt0);
            if (ord == 0)
                ord = three_way(at1, bt1);
        end
        if (ord == 0 && hx)
        begin
            ord = three_way(ax0, bx0);
            if (ord == 0)
                ord = three_way(ax1, bx1);
        end
        if (ord == 0)
            ord = (p.a.flags < p.b.flags) ? -1 : ((p.a.flags > p.b.flags) ? 1 : 0);
        r.order = (ord < 0) ? ORD_LESS : ((ord > 0) ? ORD_GREATER : ORD_EQUAL);

        r.equal = (p.a.flags == p.b.flags)
                  && !(p.a.flags[0] && (ax0 != bx0 || ax1 != bx1))
                  && !(p.a.flags[1] && (at0 != bt0 || at1 != bt1));

        if (p.req == REQ_INTERSECT)
        begin
            if (!common)
                r.status = ST_NO_COMMON;
            else if (ovl)
            begin
                r.box_valid = 1'b1;
                r.box_flags = {ht, hx};
                if (hx)
                begin
                    rx0 = ix0;
                    rx1 = ix1;
                end
                if (ht)
                begin
                    rt0 = it0;
                    rt1 = it1;
                end
            end
        end
        else if (p.a.flags != p.b.flags)
            r.status = ST_MISMATCH;
        else if (!common)
            r.status = ST_NO_COMMON;
        else if (!ovl)
            r.status = ST_GAP;
        else
        begin
            r.box_valid = 1'b1;
            r.box_flags = p.a.flags;
            if (hx)
            begin
                rx0 = (ax0 < bx0) ? ax0 : bx0;
                rx1 = (ax1 > bx1) ? ax1 : bx1;
            end
            if (ht)
            begin
                rt0 = (at0 < bt0) ? at0 : bt0;
                rt1 = (at1 > bt1) ? at1 : bt1;
            end
        end

        // inverted inputs can leave min above max; the result box is sorted
        if (rx0 > rx1)
        begin
            lo  = rx1;
            rx1 = rx0;
            rx0 = lo;
        end
        if (rt0 > rt1)
        begin
            lo  = rt1;
            rt1 = rt0;
            rt0 = lo;
        end
        r.box_xmin = rx0;
        r.box_xmax = rx1;
        r.box_tmin = rt0;
        r.box_tmax = rt1;
        return r;
    endfunction

    task automatic add_pair(input logic req,
                            input logic [1:0] af, input bound_t ax0, input bound_t ax1,
                            input bound_t at0, input bound_t at1,
                            input logic [1:0] bf, input bound_t bx0, input bound_t bx1,
                            input bound_t bt0, input bound_t bt1);
        box_pair_t p;
        p.req     = req;
        p.a.flags = af;
        p.a.xmin  = ax0;
        p.a.xmax  = ax1;
        p.a.tmin  = at0;
        p.a.tmax  = at1;
        p.b.flags = bf;
        p.b.xmin  = bx0;
        p.b.xmax  = bx1;
        p.b.tmin  = bt0;
        p.b.tmax  = bt1;
        pairs_to_send.push_back(p);
    endtask

    // mostly small bounds so that overlap, touching and nesting come up often
    task automatic pick_interval(input logic is_value, output bound_t lo, output bound_t hi);
        bound_t e0, e1, t;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
        end
        else if (mode == 1)
        begin
            lo = BMIN + bound_t'($urandom_range(0, 2));
            hi = BMAX - bound_t'($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0)
                lo = bound_t'($urandom_range(0, 8)) - 4;
            else if ($urandom_range(0, 1) == 0)
                hi = bound_t'($urandom_range(0, 8)) - 4;
        end
        else
        begin
            e0 = bound_t'($urandom_range(0, 16)) - 8;
            e1 = bound_t'($urandom_range(0, 16)) - 8;
            if (is_value)
            begin
                e0 = e0 <<< 32;
                e1 = e1 <<< 32;
                if ($urandom_range(0, 3) == 0)
                    e0 = e0 + bound_t'($urandom_range(0, 3) << 30);
            end
            // keep one in ten inverted
            if ((e0 > e1) && ($urandom_range(0, 9) != 0))
            begin
                t  = e0;
                e0 = e1;
                e1 = t;
            end
            lo = e0;
            hi = e1;
        end
    endtask

    function automatic logic idling_on();
        return (pairs_to_send.size() > QUIET_TAIL) && (((pairs_sent / 48) % 4) != 3);
    endfunction

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (!s_tvalid || s_tready)
            begin
                if (s_tvalid)
                begin
                    expected_relations.push_back(relate_boxes(on_bus));
                    pairs_sent++;
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pairs_to_send.size() > 0)
                begin
                    on_bus = pairs_to_send.pop_front();
                    s_tdata <= {4'b0,
                                on_bus.b.tmax, on_bus.b.tmin, on_bus.b.xmax, on_bus.b.xmin,
                                on_bus.b.flags,
                                on_bus.a.tmax, on_bus.a.tmin, on_bus.a.xmax, on_bus.a.xmin,
                                on_bus.a.flags};
                    s_tuser  <= on_bus.req;
                    s_tvalid <= 1'b1;
                    if (idling_on() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.topo_bits      = m_tdata[4:0];
                got.value_pos_bits = m_tdata[8:5];
                got.time_pos_bits  = m_tdata[12:9];
                got.order          = m_tdata[14:13];
                got.equal          = m_tdata[15];
                got.status         = m_tdata[17:16];
                got.box_valid      = m_tdata[18];
                got.box_flags      = m_tdata[20:19];
                got.box_xmin       = m_tdata[84:21];
                got.box_xmax       = m_tdata[148:85];
                got.box_tmin       = m_tdata[212:149];
                got.box_tmax       = m_tdata[276:213];
                results_seen++;
                if (expected_relations.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word expected none, actual %0h", $time, m_tdata);
                end
                else
                begin
                    want = expected_relations.pop_front();
                    check_field("topo_bits", 64'(want.topo_bits), 64'(got.topo_bits));
                    check_field("value_pos_bits", 64'(want.value_pos_bits),
                                64'(got.value_pos_bits));
                    check_field("time_pos_bits", 64'(want.time_pos_bits),
                                64'(got.time_pos_bits));
                    check_field("order", 64'(want.order), 64'(got.order));
                    check_field("equal", 64'(want.equal), 64'(got.equal));
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("box_valid", 64'(want.box_valid), 64'(got.box_valid));
                    check_field("box_flags", 64'(want.box_flags), 64'(got.box_flags));
                    check_field("box_xmin", want.box_xmin, got.box_xmin);
                    check_field("box_xmax", want.box_xmax, got.box_xmax);
                    check_field("box_tmin", want.box_tmin, got.box_tmin);
                    check_field("box_tmax", want.box_tmax, got.box_tmax);
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (take_gap > 0)
            begin
                take_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idling_on() && $urandom_range(0, 7) == 0)
                    take_gap = $urandom_range(1, 15);
            end
        end
    end

    // long back-pressure so the pipeline fills and s_tready drops
    initial
    begin
        wait (results_seen >= 120);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [1:0] af, bf;
        bound_t     ax0, ax1, at0, at1, bx0, bx1, bt0, bt1;

        // full-range boxes, identical
        add_pair(REQ_INTERSECT, BOTH_DIMS, BMIN, BMAX, BMIN, BMAX,
                 BOTH_DIMS, BMIN, BMAX, BMIN, BMAX);
        add_pair(REQ_UNION, BOTH_DIMS, BMIN, BMAX, BMIN, BMAX,
                 BOTH_DIMS, BMIN, BMAX, BMIN, BMAX);
        // value apart by one lsb, time touching at zero
        add_pair(REQ_INTERSECT, BOTH_DIMS, BMIN, -1, BMIN, 0,
                 BOTH_DIMS, 0, BMAX, 0, BMAX);
        add_pair(REQ_UNION, BOTH_DIMS, BMIN, -1, BMIN, 0,
                 BOTH_DIMS, 0, BMAX, 0, BMAX);
        // touching value ranges
        add_pair(REQ_INTERSECT, FLAG_VALUE, 0, 5 * Q1, 7, 3,
                 FLAG_VALUE, 5 * Q1, 9 * Q1, -4, 8);
        add_pair(REQ_UNION, FLAG_VALUE, 0, 5 * Q1, 7, 3,
                 FLAG_VALUE, 5 * Q1, 9 * Q1, -4, 8);
        // nesting both ways
        add_pair(REQ_INTERSECT, BOTH_DIMS, 0, 10 * Q1, 0, 10,
                 BOTH_DIMS, 2 * Q1, 3 * Q1, 4, 5);
        add_pair(REQ_UNION, BOTH_DIMS, 2 * Q1, 3 * Q1, 4, 5,
                 BOTH_DIMS, 0, 10 * Q1, 0, 10);
        // nothing in common
        add_pair(REQ_INTERSECT, FLAG_VALUE, 1, 2, 3, 4, FLAG_TIME, 1, 2, 3, 4);
        add_pair(REQ_UNION, FLAG_VALUE, 1, 2, 3, 4, FLAG_TIME, 1, 2, 3, 4);
        add_pair(REQ_UNION, NO_DIMS, 1, 2, 3, 4, NO_DIMS, 5, 6, 7, 8);
        add_pair(REQ_INTERSECT, NO_DIMS, 1, 2, 3, 4, NO_DIMS, 1, 2, 3, 4);
        // value shared only, b's time bounds are junk
        add_pair(REQ_UNION, BOTH_DIMS, 0, 4 * Q1, 0, 9,
                 FLAG_VALUE, Q1, 6 * Q1, BMAX, BMIN);
        add_pair(REQ_INTERSECT, BOTH_DIMS, 0, 4 * Q1, 0, 9,
                 FLAG_VALUE, Q1, 6 * Q1, BMAX, BMIN);
        // inverted bounds on a
        add_pair(REQ_INTERSECT, FLAG_VALUE, 9 * Q1, 2 * Q1, 0, 0,
                 FLAG_VALUE, 3 * Q1, 4 * Q1, 0, 0);
        add_pair(REQ_UNION, BOTH_DIMS, 9 * Q1, 2 * Q1, 8, 1,
                 BOTH_DIMS, 3 * Q1, 4 * Q1, 2, 3);
        // time before and after
        add_pair(REQ_INTERSECT, FLAG_TIME, 0, 0, 0, 3, FLAG_TIME, 0, 0, 5, 8);
        add_pair(REQ_UNION, FLAG_TIME, 0, 0, 5, 8, FLAG_TIME, 0, 0, 0, 3);
        // order falls through to the flags
        add_pair(REQ_INTERSECT, FLAG_VALUE, Q1, 2 * Q1, 0, 0,
                 BOTH_DIMS, Q1, 2 * Q1, 6, 7);
        // order decided by the later time bound
        add_pair(REQ_INTERSECT, FLAG_TIME, 0, 0, 1, 5, FLAG_TIME, 0, 0, 1, 4);
        // negative fractional values
        add_pair(REQ_UNION, FLAG_VALUE, -Q1 - 1, 7, 0, 0, FLAG_VALUE, -Q1 - 3, -Q1 + 5, 0, 0);
        // all ones against all zeros, then a box from all ones to zero against zeros
        add_pair(REQ_UNION, BOTH_DIMS, -1, -1, -1, -1, BOTH_DIMS, 0, 0, 0, 0);
        add_pair(REQ_INTERSECT, BOTH_DIMS, -1, 0, -1, 0, BOTH_DIMS, 0, 0, 0, 0);
        directed_cnt = pairs_to_send.size();

        repeat (RANDOM_PAIRS)
        begin
            af = 2'($urandom_range(0, 3));
            bf = ($urandom_range(0, 3) != 0) ? af : 2'($urandom_range(0, 3));
            pick_interval(1'b1, ax0, ax1);
            pick_interval(1'b0, at0, at1);
            if ($urandom_range(0, 6) == 0)
            begin
                bx0 = ax0;
                bx1 = ax1;
                bt0 = at0;
                bt1 = at1;
            end
            else
            begin
                pick_interval(1'b1, bx0, bx1);
                pick_interval(1'b0, bt0, bt1);
            end
            add_pair(1'($urandom_range(0, 1)), af, ax0, ax1, at0, at1, bf, bx0, bx1, bt0, bt1);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pairs_to_send.size() == 0 && !s_tvalid);
        wait (expected_relations.size() == 0);
        repeat (20) @(posedge clk);

        $display("box pairs: %0d sent (%0d directed), %0d results compared, %0d mismatches",
                 pairs_sent, directed_cnt, results_seen, mismatches);
        $display("input held by back-pressure for %0d cycles", input_stalls);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
